// ===== sv/tvbb_pkg.sv =====
// ----------------------------------------------------------------------------
// tvbb_pkg: shared types and constants for the transformed vertex bounding box
// Coordinate, coefficient and wide product types, register indexes and reset
// values of the transform registers.
// ----------------------------------------------------------------------------
package tvbb_pkg;

  localparam int COORD_WIDTH     = 32;
  localparam int FRAC_BITS       = 16;
  localparam int COEF_WIDTH      = 32;
  localparam int CFG_WIDTH       = 2 * COEF_WIDTH;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int NUM_ROWS        = 3;
  localparam int PROD_WIDTH      = COORD_WIDTH + COEF_WIDTH;
  // three products plus the scaled translation need two guard bits
  localparam int SUM_WIDTH       = PROD_WIDTH + 2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [COEF_WIDTH-1:0]  coef_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [SUM_WIDTH-1:0]   sum_t;
  typedef logic [CFG_WIDTH-1:0]          cfg_word_t;

  // one row: three linear coefficients then the translation
  typedef coef_t [3:0]                   row_coef_t;
  typedef row_coef_t [NUM_ROWS-1:0]      matrix_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_ROW0_A = 3'd0,
    REG_ROW0_B = 3'd1,
    REG_ROW1_A = 3'd2,
    REG_ROW1_B = 3'd3,
    REG_ROW2_A = 3'd4,
    REG_ROW2_B = 3'd5
  } reg_index_t;

  // identity transform
  localparam cfg_word_t ROW0_A_RESET = 64'h0000_0000_0001_0000;
  localparam cfg_word_t ROW0_B_RESET = 64'h0000_0000_0000_0000;
  localparam cfg_word_t ROW1_A_RESET = 64'h0001_0000_0000_0000;
  localparam cfg_word_t ROW1_B_RESET = 64'h0000_0000_0000_0000;
  localparam cfg_word_t ROW2_A_RESET = 64'h0000_0000_0000_0000;
  localparam cfg_word_t ROW2_B_RESET = 64'h0000_0000_0001_0000;

  // transformed point handed from the datapath to the box accumulator
  typedef struct packed {
    coord_t [NUM_ROWS-1:0] pos;
    logic                  last;
  } point_t;

endpackage

// ===== sv/tvbb_coef_regs.sv =====
// ----------------------------------------------------------------------------
// tvbb_coef_regs: transform coefficient registers
// Six 64-bit write-only registers, unpacked into a 3x4 coefficient matrix.
// ----------------------------------------------------------------------------
module tvbb_coef_regs
  import tvbb_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_data,
  output matrix_t                    matrix
);

  cfg_word_t row_a [NUM_ROWS];
  cfg_word_t row_b [NUM_ROWS];

  always_ff @(posedge clk) begin
    if (rst) begin
      row_a[0] <= ROW0_A_RESET;
      row_b[0] <= ROW0_B_RESET;
      row_a[1] <= ROW1_A_RESET;
      row_b[1] <= ROW1_B_RESET;
      row_a[2] <= ROW2_A_RESET;
      row_b[2] <= ROW2_B_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_ROW0_A: row_a[0] <= cfg_data;
        REG_ROW0_B: row_b[0] <= cfg_data;
        REG_ROW1_A: row_a[1] <= cfg_data;
        REG_ROW1_B: row_b[1] <= cfg_data;
        REG_ROW2_A: row_a[2] <= cfg_data;
        REG_ROW2_B: row_b[2] <= cfg_data;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      matrix[r][0] = row_a[r][COEF_WIDTH-1:0];
      matrix[r][1] = row_a[r][CFG_WIDTH-1:COEF_WIDTH];
      matrix[r][2] = row_b[r][COEF_WIDTH-1:0];
      matrix[r][3] = row_b[r][CFG_WIDTH-1:COEF_WIDTH];
    end
  end

endmodule

// ===== sv/tvbb_transform.sv =====
// ----------------------------------------------------------------------------
// tvbb_transform: affine transform pipeline
// Input register, product stage, row sum stage and shift/saturate stage,
// each with its own valid bit and a backward ready chain.
// ----------------------------------------------------------------------------
module tvbb_transform
  import tvbb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  matrix_t matrix,
  input  logic    in_valid,
  output logic    in_stall,
  input  coord_t  vertex_x,
  input  coord_t  vertex_y,
  input  coord_t  vertex_z,
  input  logic    last_vertex,
  output logic    pt_valid,
  input  logic    pt_ready,
  output point_t  pt
);

  // stage 1: input register
  logic   v1;
  coord_t vtx [3];
  logic   last1;
  // stage 2: products
  logic   v2;
  prod_t  prod [NUM_ROWS][3];
  coef_t  trans [NUM_ROWS];
  logic   last2;
  // stage 3: row sums
  logic   v3;
  sum_t   row_sum [NUM_ROWS];
  logic   last3;
  // stage 4: saturated coordinates
  logic   v4;

  logic   s1_ready, s2_ready, s3_ready, s4_ready;
  sum_t   sum_next [NUM_ROWS];
  coord_t sat_next [NUM_ROWS];

  assign s4_ready = !v4 || pt_ready;
  assign s3_ready = !v3 || s4_ready;
  assign s2_ready = !v2 || s3_ready;
  assign s1_ready = !v1 || s2_ready;
  assign in_stall = !s1_ready;
  assign pt_valid = v4;

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      sum_next[r] = sum_t'(prod[r][0]) + sum_t'(prod[r][1]) + sum_t'(prod[r][2])
                  + (sum_t'(trans[r]) <<< FRAC_BITS);
    end
  end

  // floor shift, then clamp to the coordinate range
  always_comb begin
    sum_t sh;
    for (int r = 0; r < NUM_ROWS; r++) begin
      sh = row_sum[r] >>> FRAC_BITS;
      if (sh > sum_t'(COORD_MAX)) begin
        sat_next[r] = COORD_MAX;
      end else if (sh < sum_t'(COORD_MIN)) begin
        sat_next[r] = COORD_MIN;
      end else begin
        sat_next[r] = sh[COORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (s1_ready) v1 <= in_valid;
      if (s2_ready) v2 <= v1;
      if (s3_ready) v3 <= v2;
      if (s4_ready) v4 <= v3;
    end

    if (in_valid && s1_ready) begin
      vtx[0] <= vertex_x;
      vtx[1] <= vertex_y;
      vtx[2] <= vertex_z;
      last1  <= last_vertex;
    end

    if (v1 && s2_ready) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= prod_t'(vtx[c]) * prod_t'(matrix[r][c]);
        end
        trans[r] <= matrix[r][3];
      end
      last2 <= last1;
    end

    if (v2 && s3_ready) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        row_sum[r] <= sum_next[r];
      end
      last3 <= last2;
    end

    if (v3 && s4_ready) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        pt.pos[r] <= sat_next[r];
      end
      pt.last <= last3;
    end
  end

endmodule

// ===== sv/tvbb_accum.sv =====
// ----------------------------------------------------------------------------
// tvbb_accum: running box and result register
// Tracks per-axis minimum and maximum; on the last point loads the result
// register and restarts the box.
// ----------------------------------------------------------------------------
module tvbb_accum
  import tvbb_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   pt_valid,
  output logic   pt_ready,
  input  point_t pt,
  output logic   out_valid,
  input  logic   out_stall,
  output coord_t min_x,
  output coord_t min_y,
  output coord_t min_z,
  output coord_t max_x,
  output coord_t max_y,
  output coord_t max_z
);

  coord_t run_min [NUM_ROWS];
  coord_t run_max [NUM_ROWS];
  coord_t min_next [NUM_ROWS];
  coord_t max_next [NUM_ROWS];
  logic   take;

  // hold a closing point only while the result register is full and blocked
  assign pt_ready = !(pt.last && out_valid && out_stall);
  assign take     = pt_valid && pt_ready;

  always_comb begin
    for (int i = 0; i < NUM_ROWS; i++) begin
      min_next[i] = ($signed(pt.pos[i]) < $signed(run_min[i])) ? pt.pos[i] : run_min[i];
      max_next[i] = ($signed(pt.pos[i]) > $signed(run_max[i])) ? pt.pos[i] : run_max[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_ROWS; i++) begin
        run_min[i] <= COORD_MAX;
        run_max[i] <= COORD_MIN;
      end
    end else begin
      if (take && pt.last) begin
        out_valid <= 1'b1;
        for (int i = 0; i < NUM_ROWS; i++) begin
          run_min[i] <= COORD_MAX;
          run_max[i] <= COORD_MIN;
        end
      end else begin
        if (out_valid && !out_stall) out_valid <= 1'b0;
        if (take) begin
          for (int i = 0; i < NUM_ROWS; i++) begin
            run_min[i] <= min_next[i];
            run_max[i] <= max_next[i];
          end
        end
      end
    end

    if (take && pt.last) begin
      min_x <= min_next[0];
      min_y <= min_next[1];
      min_z <= min_next[2];
      max_x <= max_next[0];
      max_y <= max_next[1];
      max_z <= max_next[2];
    end
  end

endmodule

// ===== sv/transformed_vertex_bounding_box_core.sv =====
// ----------------------------------------------------------------------------
// transformed_vertex_bounding_box_core: box of affinely transformed vertices
// Applies the upper three rows of a 4x4 Q16.16 transform to each vertex and
// returns the axis-aligned bounding box of a mesh on its last vertex.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one vertex request per cycle
//   while in_stall is low: vertex_x/y/z and last_vertex. Output channel
//   (out_valid / out_stall) carries one box per mesh, only for the request
//   flagged last_vertex. The box includes the last vertex; the running box
//   then restarts empty. A box is loaded into the result register after its
//   last vertex passes the input, product, row sum and shift/saturate stages.
//   Throughput: one vertex per cycle while in_stall is low, set by the
//   four-stage transform pipeline and the registered min/max update.
//   When out_stall holds a box, the pipeline keeps taking vertices until a
//   closing vertex reaches the box stage; then in_stall rises as the stages
//   fill. The user must write transform registers (cfg_write_en / cfg_index /
//   cfg_data) only while idle; the block does not enforce it. Indexes beyond
//   the list are ignored. Reset (rst, synchronous) empties the pipeline,
//   clears the running box and loads the identity transform.
// ----------------------------------------------------------------------------
module transformed_vertex_bounding_box_core
  import tvbb_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  coord_t                     vertex_x,
  input  coord_t                     vertex_y,
  input  coord_t                     vertex_z,
  input  logic                       last_vertex,
  output logic                       out_valid,
  input  logic                       out_stall,
  output coord_t                     min_x,
  output coord_t                     min_y,
  output coord_t                     min_z,
  output coord_t                     max_x,
  output coord_t                     max_y,
  output coord_t                     max_z
);

  matrix_t matrix;
  point_t  pt;
  logic    pt_valid;
  logic    pt_ready;

  tvbb_coef_regs u_coef_regs (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .matrix       (matrix)
  );

  tvbb_transform u_transform (
    .clk         (clk),
    .rst         (rst),
    .matrix      (matrix),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .vertex_x    (vertex_x),
    .vertex_y    (vertex_y),
    .vertex_z    (vertex_z),
    .last_vertex (last_vertex),
    .pt_valid    (pt_valid),
    .pt_ready    (pt_ready),
    .pt          (pt)
  );

  tvbb_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .pt_valid  (pt_valid),
    .pt_ready  (pt_ready),
    .pt        (pt),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .min_x     (min_x),
    .min_y     (min_y),
    .min_z     (min_z),
    .max_x     (max_x),
    .max_y     (max_y),
    .max_z     (max_z)
  );

endmodule
